>>> sv/lrb_pkg.sv
package lrb_pkg;

    localparam int STATE_W  = 3;
    localparam int OP_W     = 3;
    localparam int RETRY_W  = 10;
    localparam int BO_W     = 5;
    localparam int DELAY_W  = 19;
    localparam int REASON_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam int SHIFT_W  = DELAY_W + 31;

    // link states
    localparam logic [STATE_W-1:0] ST_DISABLED   = 3'd0;
    localparam logic [STATE_W-1:0] ST_INIT       = 3'd1;
    localparam logic [STATE_W-1:0] ST_CONNECTING = 3'd2;
    localparam logic [STATE_W-1:0] ST_GOT_ADDR   = 3'd3;
    localparam logic [STATE_W-1:0] ST_BACKOFF    = 3'd4;
    localparam logic [STATE_W-1:0] ST_STOPPED    = 3'd5;

    // event codes
    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_START     = 3'd1;
    localparam logic [OP_W-1:0] OP_DISCONN   = 3'd2;
    localparam logic [OP_W-1:0] OP_GOT_ADDR  = 3'd3;
    localparam logic [OP_W-1:0] OP_LOST_ADDR = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NAME_PRESENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_CEILING = 3'd4;

    localparam logic [BO_W-1:0]     EXP_CAP        = 5'd31;
    localparam logic [RETRY_W-1:0]  RETRY_MAX      = 10'd1023;
    localparam logic [REASON_W-1:0] REASON_NO_NAME = 16'd2;

    localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT   = 10'd6;
    localparam logic [DELAY_W-1:0] RST_DELAY_FLOOR   = 19'd500;
    localparam logic [DELAY_W-1:0] RST_DELAY_CEILING = 19'd8000;

    typedef struct packed {
        logic                link_enabled;
        logic                name_present;
        logic [RETRY_W-1:0]  retry_limit;
        logic [DELAY_W-1:0]  delay_floor_ms;
        logic [DELAY_W-1:0]  delay_ceiling_ms;
    } lrb_cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                connect_ok;
        logic [REASON_W-1:0] disconnect_reason;
    } lrb_item_t;

    typedef struct packed {
        logic [REASON_W-1:0] last_reason;
        logic [RETRY_W-1:0]  retries_so_far;
        logic [DELAY_W-1:0]  current_delay_ms;
        logic                is_connecting;
        logic                is_connected;
        logic                address_held;
        logic                connect_issued;
        logic [STATE_W-1:0]  link_state;
    } lrb_result_t;

endpackage

>>> sv/lrb_backoff_calc.sv
module lrb_backoff_calc (
    input  logic [lrb_pkg::BO_W-1:0]    exp_in,
    input  logic [lrb_pkg::DELAY_W-1:0] floor_ms,
    input  logic [lrb_pkg::DELAY_W-1:0] ceiling_ms,
    output logic [lrb_pkg::DELAY_W-1:0] backoff_ms
);
    import lrb_pkg::*;

    logic [SHIFT_W-1:0] shifted;
    logic [DELAY_W-1:0] top;
    logic [31:0]        cand;
    logic               overflow;

    always_comb begin
        top      = (ceiling_ms == '0) ? DELAY_W'(1) : ceiling_ms;
        shifted  = {{(SHIFT_W-DELAY_W){1'b0}}, floor_ms} << exp_in;
        overflow = |shifted[SHIFT_W-1:32];
        // saturate an overflowing shift to the ceiling
        cand     = overflow ? {{(32-DELAY_W){1'b0}}, top} : shifted[31:0];
        if (cand < {{(32-DELAY_W){1'b0}}, floor_ms}) begin
            backoff_ms = floor_ms;
        end else if (cand > {{(32-DELAY_W){1'b0}}, top}) begin
            backoff_ms = top;
        end else begin
            backoff_ms = cand[DELAY_W-1:0];
        end
    end

endmodule

>>> sv/lrb_ctrl.sv
module lrb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  lrb_pkg::lrb_cfg_t   cfg,
    input  lrb_pkg::lrb_item_t  item,
    output lrb_pkg::lrb_result_t result
);
    import lrb_pkg::*;

    logic [STATE_W-1:0]  state_reg,   state_next;
    logic [RETRY_W-1:0]  retry_reg,   retry_next;
    logic [BO_W-1:0]     bo_reg,      bo_next;
    logic [DELAY_W-1:0]  delay_reg,   delay_next;
    logic [DELAY_W-1:0]  count_reg,   count_next;
    logic [REASON_W-1:0] reason_reg,  reason_next;
    logic                addr_reg,    addr_next;

    logic [BO_W-1:0]     bo_inc;
    logic [DELAY_W-1:0]  new_delay;
    logic                connect_req;
    logic                backoff_req;
    logic                issued;

    assign bo_inc = (bo_reg < EXP_CAP) ? bo_reg + BO_W'(1) : bo_reg;

    lrb_backoff_calc u_calc (
        .exp_in     (bo_inc),
        .floor_ms   (cfg.delay_floor_ms),
        .ceiling_ms (cfg.delay_ceiling_ms),
        .backoff_ms (new_delay)
    );

    always_comb begin
        state_next  = state_reg;
        retry_next  = retry_reg;
        bo_next     = bo_reg;
        delay_next  = delay_reg;
        count_next  = count_reg;
        reason_next = reason_reg;
        addr_next   = addr_reg;
        connect_req = 1'b0;
        backoff_req = 1'b0;
        issued      = 1'b0;

        unique case (item.op)
            OP_TICK: begin
                if (!cfg.link_enabled) begin
                    state_next = ST_DISABLED;
                end else if (state_reg == ST_BACKOFF) begin
                    if (count_reg != '0) begin
                        count_next = count_reg - DELAY_W'(1);
                    end
                    connect_req = (count_next == '0);
                end
            end
            OP_START: begin
                connect_req = 1'b1;
            end
            OP_DISCONN: begin
                reason_next = item.disconnect_reason;
                addr_next   = 1'b0;
                if (!cfg.link_enabled) begin
                    state_next = ST_DISABLED;
                end else if (cfg.retry_limit != '0 && retry_reg >= cfg.retry_limit) begin
                    retry_next = '0;
                    bo_next    = '0;
                    state_next = ST_STOPPED;
                end else begin
                    backoff_req = 1'b1;
                end
            end
            OP_GOT_ADDR: begin
                addr_next   = 1'b1;
                retry_next  = '0;
                bo_next     = '0;
                delay_next  = '0;
                count_next  = '0;
                reason_next = '0;
                state_next  = cfg.link_enabled ? ST_GOT_ADDR : ST_DISABLED;
            end
            OP_LOST_ADDR: begin
                addr_next = 1'b0;
                if (!cfg.link_enabled) begin
                    state_next = ST_DISABLED;
                end else begin
                    backoff_req = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (connect_req) begin
            if (!cfg.link_enabled) begin
                state_next = ST_DISABLED;
            end else if (!cfg.name_present) begin
                reason_next = REASON_NO_NAME;
                backoff_req = 1'b1;
            end else begin
                issued = 1'b1;
                if (!item.connect_ok) begin
                    backoff_req = 1'b1;
                end else begin
                    if (retry_reg < RETRY_MAX) begin
                        retry_next = retry_reg + RETRY_W'(1);
                    end
                    reason_next = '0;
                    delay_next  = '0;
                    state_next  = ST_CONNECTING;
                end
            end
        end

        if (backoff_req) begin
            bo_next    = bo_inc;
            delay_next = new_delay;
            count_next = new_delay;
            state_next = ST_BACKOFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_INIT;
            retry_reg  <= '0;
            bo_reg     <= '0;
            delay_reg  <= '0;
            count_reg  <= '0;
            reason_reg <= '0;
            addr_reg   <= 1'b0;
        end else if (step_en) begin
            state_reg  <= state_next;
            retry_reg  <= retry_next;
            bo_reg     <= bo_next;
            delay_reg  <= delay_next;
            count_reg  <= count_next;
            reason_reg <= reason_next;
            addr_reg   <= addr_next;
        end
    end

    always_comb begin
        result.link_state       = state_next;
        result.connect_issued   = issued;
        result.address_held     = addr_next;
        result.is_connected     = cfg.link_enabled && state_next == ST_GOT_ADDR && addr_next;
        result.is_connecting    = cfg.link_enabled &&
                                  (state_next == ST_CONNECTING || state_next == ST_BACKOFF);
        result.current_delay_ms = delay_next;
        result.retries_so_far   = retry_next;
        result.last_reason      = reason_next;
    end

endmodule

>>> sv/link_retry_backoff_fsm_top.sv
// A transaction accepted on the slave side loads the input register, and once the master
// side is not stalled its result is loaded into the result register.
// Throughput: one transaction per cycle while the master side is not stalled; the
// single-pass next-state logic sets this.
// Reset (aresetn low, synchronous): link state init, counters, delay, countdown,
// reason and address cleared, configuration back to its defaults, both stages empty.
module link_retry_backoff_fsm_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,  // connect_ok, disconnect_reason, pad
    input  logic [lrb_pkg::OP_W-1:0]       s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // link_state, connect_issued, address_held, is_connected, is_connecting,
    // current_delay_ms, retries_so_far, last_reason, pad
    output logic [55:0]                    m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [lrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import lrb_pkg::*;

    lrb_cfg_t    cfg_reg;
    lrb_item_t   item_reg;
    logic        item_valid_reg;
    lrb_result_t result;
    lrb_result_t result_reg;
    logic        out_valid_reg;
    logic        step_en;

    // advance the held transaction whenever the result stage is free or draining
    assign step_en  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.link_enabled     <= 1'b1;
            cfg_reg.name_present     <= 1'b1;
            cfg_reg.retry_limit      <= RST_RETRY_LIMIT;
            cfg_reg.delay_floor_ms   <= RST_DELAY_FLOOR;
            cfg_reg.delay_ceiling_ms <= RST_DELAY_CEILING;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LINK_ENABLED:  cfg_reg.link_enabled     <= cfg_wdata[0];
                REG_NAME_PRESENT:  cfg_reg.name_present     <= cfg_wdata[0];
                REG_RETRY_LIMIT:   cfg_reg.retry_limit      <= cfg_wdata[RETRY_W-1:0];
                REG_DELAY_FLOOR:   cfg_reg.delay_floor_ms   <= cfg_wdata[DELAY_W-1:0];
                REG_DELAY_CEILING: cfg_reg.delay_ceiling_ms <= cfg_wdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.op                <= s_tuser;
            item_reg.connect_ok        <= s_tdata[0];
            item_reg.disconnect_reason <= s_tdata[REASON_W:1];
        end
    end

    lrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(56 - $bits(lrb_result_t)){1'b0}}, result_reg};

endmodule
